>>> hdl/bgd_pkg.sv
// Shared types and constants for the button gesture detector.
// Holds the gesture codes, register indexes and the configuration and state records.
// No dependencies.
`timescale 1ns / 1ps

package bgd_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CLICK_W = 2;

    typedef enum logic [1:0] {
        GESTURE_NONE   = 2'd0,
        GESTURE_SINGLE = 2'd1,
        GESTURE_DOUBLE = 2'd2,
        GESTURE_LONG   = 2'd3
    } gesture_t;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd400;

    localparam logic [CLICK_W-1:0] CLICKS_FOR_DOUBLE = 2'd2;
    localparam logic [CLICK_W-1:0] CLICKS_ONE        = 2'd1;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_click_ms;
    } bgd_cfg_t;

    typedef struct packed {
        logic                held;
        logic [TIME_W-1:0]   last_edge_time;
        logic [TIME_W-1:0]   press_start_time;
        logic                long_reported;
        logic [CLICK_W-1:0]  clicks;
        logic [TIME_W-1:0]   release_time;
    } bgd_state_t;

endpackage

>>> hdl/bgd_core.sv
// Gesture decision logic and the button state registers.
// One sample is evaluated per step; depends on bgd_pkg.
`timescale 1ns / 1ps

module bgd_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [31:0]              now_ms,
    input  logic                     raw_pressed,
    input  bgd_pkg::bgd_cfg_t        cfg,
    output bgd_pkg::gesture_t        gesture
);
    import bgd_pkg::*;

    bgd_state_t         state_reg;
    bgd_state_t         state_next;
    logic [TIME_W-1:0]  edge_diff;
    logic [TIME_W-1:0]  hold_diff;
    logic [TIME_W-1:0]  idle_diff;
    logic [CLICK_W-1:0] clicks_inc;

    always_comb
    begin
        state_next = state_reg;
        gesture    = GESTURE_NONE;
        clicks_inc = state_reg.clicks + CLICKS_ONE;

        // Differences wrap modulo the timestamp width by construction.
        edge_diff = now_ms - state_reg.last_edge_time;
        if (edge_diff > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms})
        begin
            if (raw_pressed && !state_reg.held)
            begin
                state_next.held             = 1'b1;
                state_next.last_edge_time   = now_ms;
                state_next.press_start_time = now_ms;
                state_next.long_reported    = 1'b0;
            end
            else if (!raw_pressed && state_reg.held)
            begin
                state_next.held           = 1'b0;
                state_next.last_edge_time = now_ms;
                if (!state_reg.long_reported)
                begin
                    state_next.release_time = now_ms;
                    if (clicks_inc == CLICKS_FOR_DOUBLE)
                    begin
                        gesture           = GESTURE_DOUBLE;
                        state_next.clicks = '0;
                    end
                    else
                    begin
                        state_next.clicks = clicks_inc;
                    end
                end
            end
        end

        // The later checks see the state as updated by the edge check.
        hold_diff = now_ms - state_next.press_start_time;
        if (state_next.held && !state_next.long_reported &&
            hold_diff >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms})
        begin
            gesture                  = GESTURE_LONG;
            state_next.long_reported = 1'b1;
            state_next.clicks        = '0;
        end

        idle_diff = now_ms - state_next.release_time;
        if (state_next.clicks == CLICKS_ONE && !state_next.held &&
            idle_diff > {{(TIME_W-CFG_W){1'b0}}, cfg.double_click_ms})
        begin
            gesture           = GESTURE_SINGLE;
            state_next.clicks = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    a_clicks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.clicks == '0 || state_reg.clicks == CLICKS_ONE)
        else $error("click count left its legal range");

    a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step && gesture == GESTURE_LONG |=> state_reg.long_reported && state_reg.held)
        else $error("long press reported without marking the press");

    a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && gesture == GESTURE_DOUBLE |=> state_reg.clicks == '0 && !state_reg.held)
        else $error("double click left clicks counted");

endmodule

>>> hdl/button_gesture_detector_unit.sv
// Top level of the button gesture detector: stream ports, configuration registers,
// input and result registers around the decision logic. Depends on bgd_pkg and bgd_core.
`timescale 1ns / 1ps

// One sample transaction in, one gesture transaction out. A new sample can be
// accepted in every cycle while the input register is empty or the result register is
// free or being taken. The accepting edge loads the input register; a later edge that
// finds the result register free or being taken does the gesture decision and state
// update and loads the result register. The whole chain stalls only when the result
// register is full and not being taken. Configuration writes take effect at once and
// should be made while no sample is in flight.
module button_gesture_detector_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] now_ms, [32] raw_pressed, [39:33] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [1:0] gesture, [7:2] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import bgd_pkg::*;

    bgd_cfg_t          cfg_reg;
    logic              in_valid_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              in_pressed_reg;
    logic              out_valid_reg;
    gesture_t          out_gesture_reg;
    gesture_t          gesture;
    logic              advance;
    logic              step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms   <= LONG_PRESS_RESET;
            cfg_reg.double_click_ms <= DOUBLE_CLICK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce_ms     <= cfg_wdata;
                REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_wdata;
                REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_now_reg     <= s_tdata[31:0];
            in_pressed_reg <= s_tdata[32];
        end
        if (step)
        begin
            out_gesture_reg <= gesture;
        end
    end

    bgd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .now_ms      (in_now_reg),
        .raw_pressed (in_pressed_reg),
        .cfg         (cfg_reg),
        .gesture     (gesture)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_gesture_reg};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input refused with an empty input register");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready && !step)
        else $error("sample moved while the result register was stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("evaluated sample produced no result");

endmodule

>>> tb/tb_button_gesture_detector_unit.sv
// Self-checking testbench for button_gesture_detector_unit: drives button samples with
// random gaps and stalls, predicts each gesture code and compares it on the result stream.
// Depends on bgd_pkg and the button_gesture_detector_unit RTL.
`timescale 1ns / 1ps

module tb_button_gesture_detector_unit;

    import bgd_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [TIME_W-1:0] now;
        logic              pressed;
    } sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [31:0] now_ms, [32] raw_pressed, [39:33] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [1:0] gesture, [7:2] zero
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    sample_t  sample_q[$];
    gesture_t gesture_q[$];

    bgd_cfg_t   timing;
    bgd_state_t button;

    logic [TIME_W-1:0] t_now = '0;
    int unsigned       queued = 0;
    int unsigned       errors = 0;
    int unsigned       cycles = 0;
    bit                idle_on = 1'b1;
    bit                s_taken = 1'b0;
    int unsigned       s_gap = 0;
    int unsigned       m_stall = 0;

    button_gesture_detector_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("button_gesture_detector_unit verification failed");
            $finish;
        end
    end

    // Debounce, long press and click window rules for one sample. All time
    // differences are 32-bit and wrap, so backward timestamps need no special case.
    function automatic gesture_t predict_gesture(input logic [TIME_W-1:0] now,
                                                 input logic pressed);
        gesture_t          ev;
        logic [TIME_W-1:0] since;
        ev = GESTURE_NONE;
        since = now - button.last_edge_time;
        if (since > TIME_W'(timing.debounce_ms))
        begin
            if (pressed && !button.held)
            begin
                button.held = 1'b1;
                button.last_edge_time = now;
                button.press_start_time = now;
                button.long_reported = 1'b0;
            end
            else if (!pressed && button.held)
            begin
                button.held = 1'b0;
                button.last_edge_time = now;
                if (!button.long_reported)
                begin
                    button.clicks = button.clicks + 2'd1;
                    button.release_time = now;
                    if (button.clicks == CLICKS_FOR_DOUBLE)
                    begin
                        ev = GESTURE_DOUBLE;
                        button.clicks = '0;
                    end
                end
            end
        end
        since = now - button.press_start_time;
        if (button.held && !button.long_reported && since >= TIME_W'(timing.long_press_ms))
        begin
            ev = GESTURE_LONG;
            button.long_reported = 1'b1;
            button.clicks = '0;
        end
        since = now - button.release_time;
        if (button.clicks == CLICKS_ONE && !button.held &&
            since > TIME_W'(timing.double_click_ms))
        begin
            ev = GESTURE_SINGLE;
            button.clicks = '0;
        end
        return ev;
    endfunction

    // Results are checked before the prediction for this edge is queued.
    always @(posedge clk)
    begin : result_check
        gesture_t got;
        gesture_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = gesture_t'(m_tdata[1:0]);
                if (gesture_q.size() == 0)
                begin
                    $display("%0t: unexpected gesture transaction, expected none, got %0d",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = gesture_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: gesture mismatch, expected %0d, got %0d",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                gesture_q.push_back(predict_gesture(s_tdata[31:0], s_tdata[32]));
                s_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : sample_send
        sample_t nxt;
        if (rst_n && !(s_tvalid && !s_taken))
        begin
            s_taken = 1'b0;
            if (s_gap > 0)
            begin
                s_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() == 0)
                s_tvalid <= 1'b0;
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                s_gap = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end
            else
            begin
                nxt = sample_q.pop_front();
                s_tdata <= {7'd0, nxt.pressed, nxt.now};
                s_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_stall > 0)
            begin
                m_stall--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                m_stall = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic add_sample(input logic [TIME_W-1:0] at, input logic pressed);
        sample_t s;
        s.now = at;
        s.pressed = pressed;
        sample_q.push_back(s);
        queued++;
        t_now = at;
    endtask

    task automatic advance(input int unsigned delta, input logic pressed);
        add_sample(t_now + delta, pressed);
    endtask

    // A value one below, at or one above a threshold.
    function automatic int unsigned near_edge(input int unsigned base);
        if (base == 0)
            return $urandom_range(0, 1);
        return base - 1 + $urandom_range(0, 2);
    endfunction

    // The stream is quiet once every queued sample has been sent and every
    // expected gesture has arrived; each sample gives exactly one result.
    task automatic wait_idle();
        while (sample_q.size() != 0 || s_tvalid || gesture_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEBOUNCE:     timing.debounce_ms = val;
            REG_LONG_PRESS:   timing.long_press_ms = val;
            REG_DOUBLE_CLICK: timing.double_click_ms = val;
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                              input logic [CFG_W-1:0] dc);
        wait_idle();
        write_cfg(REG_DEBOUNCE, db);
        write_cfg(REG_LONG_PRESS, lp);
        write_cfg(REG_DOUBLE_CLICK, dc);
    endtask

    // Mostly complete gestures with random timing around the current settings,
    // mixed with contact bounce, threshold hits and raw noise.
    task automatic random_gestures(input int unsigned n);
        int unsigned db;
        int unsigned lp;
        int unsigned dc;
        int unsigned stop;
        int unsigned reps;
        db = 32'(timing.debounce_ms);
        lp = 32'(timing.long_press_ms);
        dc = 32'(timing.double_click_ms);
        stop = queued + n;
        if ($urandom_range(0, 2) == 0)
            t_now = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        while (queued < stop)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    advance(db + $urandom_range(1, 30), 1'b1);
                    advance(db + 1 + $urandom_range(0, lp / 2), 1'b0);
                    advance(dc + $urandom_range(1, 40), 1'b0);
                end
                2, 3:
                begin
                    advance(db + $urandom_range(1, 30), 1'b1);
                    advance(db + 1 + $urandom_range(0, lp / 2), 1'b0);
                    advance(db + 1 + $urandom_range(0, dc / 2), 1'b1);
                    advance(db + 1 + $urandom_range(0, lp / 2), 1'b0);
                    advance(dc + $urandom_range(0, 40), 1'b0);
                end
                4, 5:
                begin
                    advance(db + $urandom_range(1, 30), 1'b1);
                    advance(near_edge(lp), 1'b1);
                    advance($urandom_range(1, lp / 2 + 1), 1'b1);
                    advance(db + $urandom_range(1, 10), 1'b0);
                end
                6:
                begin
                    reps = $urandom_range(2, 5);
                    repeat (reps)
                        advance($urandom_range(0, db), 1'($urandom_range(0, 1)));
                end
                7:
                begin
                    advance(near_edge(db), 1'b1);
                    advance(near_edge(db), 1'b0);
                    advance(near_edge(dc), 1'b0);
                end
                8:
                begin
                    reps = $urandom_range(1, 3);
                    repeat (reps)
                        add_sample($urandom, 1'($urandom_range(0, 1)));
                end
                default:
                    advance($urandom_range(0, 3000), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial
    begin
        timing.debounce_ms = DEBOUNCE_RESET;
        timing.long_press_ms = LONG_PRESS_RESET;
        timing.double_click_ms = DOUBLE_CLICK_RESET;
        button = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: a quiet sample inside the debounce time, a double
        // click, a single click on the window boundary, a long press just at
        // its threshold, contact bounce, and timestamps wrapping or going back.
        add_sample(32'd0, 1'b0);
        add_sample(32'd100, 1'b1);
        add_sample(32'd200, 1'b0);
        add_sample(32'd300, 1'b0);
        add_sample(32'd400, 1'b1);
        add_sample(32'd500, 1'b0);
        add_sample(32'd1000, 1'b1);
        add_sample(32'd1100, 1'b0);
        add_sample(32'd1500, 1'b0);
        add_sample(32'd1501, 1'b0);
        add_sample(32'd2000, 1'b1);
        add_sample(32'd2999, 1'b1);
        add_sample(32'd3000, 1'b1);
        add_sample(32'd3100, 1'b0);
        add_sample(32'd4000, 1'b1);
        add_sample(32'd4030, 1'b0);
        add_sample(32'd4050, 1'b0);
        add_sample(32'd4051, 1'b0);
        add_sample(32'd4060, 1'b1);
        add_sample(32'd4452, 1'b0);
        add_sample(32'hFFFF_FFC0, 1'b1);
        add_sample(32'h0000_0010, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b1);
        add_sample(32'h7FFF_0000, 1'b0);

        // Every threshold at zero: a press reports its long press at once.
        // The sender holds back here until all results are in.
        set_timing(16'd0, 16'd0, 16'd0);
        write_cfg(REG_UNUSED, 16'hFFFF);
        advance(1, 1'b1);
        advance(0, 1'b0);
        advance(1, 1'b0);
        advance(1, 1'b1);
        advance(5, 1'b1);
        advance(1, 1'b0);
        random_gestures(40);

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        advance(32'h0001_0000, 1'b1);
        advance(32'h0000_FFFE, 1'b1);
        advance(1, 1'b1);
        advance(32'h0001_0000, 1'b0);
        random_gestures(60);

        set_timing(16'd5, 16'd40, 16'd30);
        random_gestures(80);

        set_timing(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 3000)),
                   CFG_W'($urandom_range(0, 1000)));
        random_gestures(60);

        set_timing(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        random_gestures(60);

        set_timing(DEBOUNCE_RESET, LONG_PRESS_RESET, DOUBLE_CLICK_RESET);
        idle_on = 1'b0;
        random_gestures(50);

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0 && gesture_q.size() == 0)
            $display("button_gesture_detector_unit verification clean");
        else
            $display("button_gesture_detector_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/bgd_pkg.sv
hdl/bgd_core.sv
hdl/button_gesture_detector_unit.sv
tb/tb_button_gesture_detector_unit.sv
